@@ src/lrupr_pkg.sv @@
// lrupr_pkg: shared widths, state encoding and cell-chain structs for the lru page table
// no dependencies; imported by lrupr_cell and lru_page_replacement_top
package lrupr_pkg;

    localparam int PAGE_W            = 16;
    localparam int FRAME_IDX_W       = 6;
    localparam int CNT_W             = 32;
    localparam int FRAME_COUNT_DEF   = 4;
    localparam int FRAME_COUNT_MAX   = 64;
    localparam int S_DATA_W          = 16;
    localparam int M_DATA_W          = 72;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_UPD  = 3'b100
    } t_state;

    // ripple from frame 0 upward
    typedef struct packed {
        logic                   found;
        logic                   empty;
        logic [FRAME_IDX_W-1:0] hit_rank;
        logic [FRAME_IDX_W-1:0] idx;
    } t_chain;

    // broadcast from the controller to every cell
    typedef struct packed {
        logic                   upd;
        logic                   clear;
        logic                   found;
        logic                   empty;
        logic [FRAME_IDX_W-1:0] limit;
    } t_cmd;

endpackage

@@ src/lrupr_cell.sv @@
// lrupr_cell: one frame of the table, holding page, valid bit and recency rank
// depends on lrupr_pkg; chained by lru_page_replacement_top
module lrupr_cell #(
    parameter int FRAME_COUNT = lrupr_pkg::FRAME_COUNT_DEF,
    parameter int IDX         = 0
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [lrupr_pkg::PAGE_W-1:0] i_page,
    input  lrupr_pkg::t_cmd             i_cmd,
    input  lrupr_pkg::t_chain           i_chain,
    output lrupr_pkg::t_chain           o_chain,
    output logic                        o_valid
);
    import lrupr_pkg::*;

    localparam int RW = $clog2(FRAME_COUNT);

    logic [PAGE_W-1:0] r_page;
    logic              r_valid;
    logic [RW-1:0]     r_rank;
    logic              w_match;
    logic              w_first_empty;
    logic              w_oldest;
    logic              w_sel;

    assign w_match       = r_valid && (r_page == i_page) && !i_chain.found;
    assign w_first_empty = !r_valid && !i_chain.empty;
    assign w_oldest      = r_valid && (r_rank == RW'(FRAME_COUNT - 1));

    always_comb begin
        if (i_cmd.found) begin
            w_sel = w_match;
        end else if (i_cmd.empty) begin
            w_sel = w_first_empty;
        end else begin
            w_sel = w_oldest;
        end
    end

    always_comb begin
        o_chain.found    = i_chain.found | w_match;
        o_chain.empty    = i_chain.empty | !r_valid;
        o_chain.hit_rank = i_chain.hit_rank
                         | (w_match ? FRAME_IDX_W'(r_rank) : '0);
        o_chain.idx      = i_chain.idx | (w_sel ? FRAME_IDX_W'(IDX) : '0);
    end

    assign o_valid = r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_rank  <= '0;
        end else if (i_cmd.upd) begin
            if (i_cmd.clear) begin
                r_valid <= 1'b0;
                r_rank  <= '0;
            end else if (w_sel) begin
                r_valid <= 1'b1;
                r_rank  <= '0;
            end else if (r_valid && (!i_cmd.found || r_rank < i_cmd.limit[RW-1:0])) begin
                r_rank <= r_rank + 1'b1;
            end
        end
    end

    // page payload, no reset
    always_ff @(posedge i_clk) begin
        if (i_cmd.upd && !i_cmd.clear && w_sel && !i_cmd.found) begin
            r_page <= i_page;
        end
    end

endmodule

@@ src/lru_page_replacement_top.sv @@
// lru_page_replacement_top: fully associative lru page table built from a chain of frame cells
// result: scan state, then update state; registered on update, which waits for a free output; held until taken
// one request at a time: accept, lookup over the cell chain, update, then ready again
// reset: synchronous active low; empties all frames, clears ranks and both counters
// depends on lrupr_pkg and lrupr_cell
module lru_page_replacement_top #(
    parameter int FRAME_COUNT = lrupr_pkg::FRAME_COUNT_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    input  logic [lrupr_pkg::S_DATA_W-1:0] i_s_axis_tdata,  // page_number
    input  logic                          i_s_axis_tlast,  // end_of_run
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    output logic [lrupr_pkg::M_DATA_W-1:0] o_m_axis_tdata,  // hit, frame_index, hit_count, fault_count, pad
    output logic                          o_m_axis_tlast   // run_done
);
    import lrupr_pkg::*;

    t_state                 r_state;
    t_state                 n_state;
    logic [PAGE_W-1:0]      r_page;
    logic                   r_done;
    logic                   r_found;
    logic                   r_empty;
    logic [FRAME_IDX_W-1:0] r_hit_rank;
    logic [CNT_W-1:0]       r_hits;
    logic [CNT_W-1:0]       r_faults;
    logic [CNT_W-1:0]       n_hits;
    logic [CNT_W-1:0]       n_faults;
    logic                   r_out_valid;
    logic                   r_out_hit;
    logic [FRAME_IDX_W-1:0] r_out_frame;
    logic [CNT_W-1:0]       r_out_hits;
    logic [CNT_W-1:0]       r_out_faults;
    logic                   r_out_last;
    logic                   w_in_xfer;
    logic                   w_upd;
    t_cmd                   w_cmd;
    t_chain                 w_chain [FRAME_COUNT+1];
    logic [FRAME_COUNT-1:0] w_valid;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign w_in_xfer       = i_s_axis_tvalid && o_s_axis_tready;
    assign w_upd           = (r_state == S_UPD) && (!r_out_valid || i_m_axis_tready);

    assign w_cmd.upd   = w_upd;
    assign w_cmd.clear = r_done;
    assign w_cmd.found = r_found;
    assign w_cmd.empty = r_empty;
    assign w_cmd.limit = r_hit_rank;

    assign w_chain[0] = '0;

    for (genvar g = 0; g < FRAME_COUNT; g++) begin : g_cell
        lrupr_cell #(
            .FRAME_COUNT(FRAME_COUNT),
            .IDX        (g)
        ) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_page (r_page),
            .i_cmd  (w_cmd),
            .i_chain(w_chain[g]),
            .o_chain(w_chain[g+1]),
            .o_valid(w_valid[g])
        );
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (w_in_xfer) n_state = S_SCAN;
            S_SCAN: n_state = S_UPD;
            S_UPD:  if (w_upd) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_hits   = r_hits;
        n_faults = r_faults;
        if (r_found) begin
            if (r_hits != '1) n_hits = r_hits + 1'b1;
        end else begin
            if (r_faults != '1) n_faults = r_faults + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_hits      <= '0;
            r_faults    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_upd) begin
                r_out_valid <= 1'b1;
                r_hits      <= r_done ? '0 : n_hits;
                r_faults    <= r_done ? '0 : n_faults;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_page <= i_s_axis_tdata[PAGE_W-1:0];
            r_done <= i_s_axis_tlast;
        end
        if (r_state == S_SCAN) begin
            r_found    <= w_chain[FRAME_COUNT].found;
            r_empty    <= w_chain[FRAME_COUNT].empty;
            r_hit_rank <= w_chain[FRAME_COUNT].hit_rank;
        end
        if (w_upd) begin
            r_out_hit    <= r_found;
            r_out_frame  <= w_chain[FRAME_COUNT].idx;
            r_out_hits   <= n_hits;
            r_out_faults <= n_faults;
            r_out_last   <= r_done;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tlast  = r_out_last;
    assign o_m_axis_tdata  = {1'b0, r_out_faults, r_out_hits, r_out_frame, r_out_hit};

    a_scan_after_xfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer |=> (r_state == S_SCAN))
        else $error("accepted request did not start a lookup");

    a_out_from_upd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_UPD))
        else $error("result appeared without an update cycle");

    a_frame_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ({1'b0, r_out_frame} < (FRAME_IDX_W+1)'(FRAME_COUNT)))
        else $error("frame index out of range");

    a_clear_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_upd && r_done) |=> (w_valid == '0) && (r_hits == '0) && (r_faults == '0))
        else $error("table not cleared after end of run");

endmodule
